// ===== design/fpsd_pkg.sv =====
package fpsd_pkg;

    // default field widths
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int OUT_WIDTH_DEF    = 32;

    // growth of a stencil sum over one sample: the largest sum of
    // coefficient magnitudes is 320, so nine bits cover it with sign
    localparam int COEF_GROWTH = 9;

    // configuration registers
    localparam int SCALE_W    = 24;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT = CFG_IDX_W'(1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(0);

    // window of samples and the sample counter
    localparam int            WIN_DEPTH = 5;
    localparam int            COUNT_W   = 3;
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(WIN_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_LAST_FILL = COUNT_W'(WIN_DEPTH - 1);

    // result jobs, in the order they are emitted for one sample
    localparam int NUM_JOBS = 6;

    typedef enum logic [2:0] {
        JOB_ERR  = 3'd0,   // sequence too short
        JOB_FWD0 = 3'd1,   // first point, forward stencil
        JOB_FWD1 = 3'd2,   // second point, forward stencil
        JOB_CEN  = 3'd3,   // interior point, central stencil
        JOB_BWD1 = 3'd4,   // second to last point, backward stencil
        JOB_BWD0 = 3'd5    // last point, backward stencil
    } job_t;

    // flags that travel with each result down the pipeline
    typedef struct packed {
        logic final_res;
        logic too_short;
    } res_tag_t;

endpackage

// ===== design/fpsd_cell.sv =====
module fpsd_cell
    import fpsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift_en,
    input  logic [SAMPLE_WIDTH-1:0] d,
    output logic [SAMPLE_WIDTH-1:0] q
);

    logic [SAMPLE_WIDTH-1:0] data_reg;
    logic [SAMPLE_WIDTH-1:0] data_next;

    // take the neighbor's sample on every shift
    always_comb
    begin
        data_next = shift_en ? d : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

// ===== design/fpsd_seq.sv =====
module fpsd_seq
    import fpsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int SUM_W = SAMPLE_WIDTH + COEF_GROWTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    last,
    output logic                    shift_en,
    input  logic [SAMPLE_WIDTH-1:0] taps [WIN_DEPTH],
    input  logic                    post_ready,
    output logic                    s1_valid,
    output logic signed [SUM_W-1:0] s1_sum,
    output res_tag_t                s1_tag
);

    localparam logic signed [SUM_W-1:0] K4   = SUM_W'(4);
    localparam logic signed [SUM_W-1:0] K6   = SUM_W'(6);
    localparam logic signed [SUM_W-1:0] K11  = SUM_W'(11);
    localparam logic signed [SUM_W-1:0] K16  = SUM_W'(16);
    localparam logic signed [SUM_W-1:0] K20  = SUM_W'(20);
    localparam logic signed [SUM_W-1:0] K30  = SUM_W'(30);
    localparam logic signed [SUM_W-1:0] K35  = SUM_W'(35);
    localparam logic signed [SUM_W-1:0] K56  = SUM_W'(56);
    localparam logic signed [SUM_W-1:0] K104 = SUM_W'(104);
    localparam logic signed [SUM_W-1:0] K114 = SUM_W'(114);

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [NUM_JOBS-1:0] pending_reg;
    logic [NUM_JOBS-1:0] pending_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic signed [SUM_W-1:0] s1_sum_next;
    res_tag_t            s1_tag_reg;
    res_tag_t            s1_tag_next;

    logic [NUM_JOBS-1:0] lowest_bit;
    logic [NUM_JOBS-1:0] remaining;
    logic [NUM_JOBS-1:0] new_jobs;
    logic [COUNT_W-1:0]  count_fill;
    logic                s1_en;
    logic                issue;
    logic                in_ready;
    logic                accept;
    job_t                cur_job;
    logic signed [SUM_W-1:0] f0, f1, f2, f3, f4;
    logic signed [SUM_W-1:0] stencil_sum;

    // the lowest-numbered pending job goes out first
    assign lowest_bit = pending_reg & (~pending_reg + NUM_JOBS'(1));
    assign remaining  = pending_reg & ~lowest_bit;

    assign s1_en    = !s1_valid_reg || post_ready;
    assign issue    = (pending_reg != '0) && s1_en;
    assign in_ready = (pending_reg == '0) || ((remaining == '0) && issue);
    assign accept   = in_valid && in_ready;
    assign in_stall = !in_ready;
    assign shift_en = accept;

    always_comb
    begin
        cur_job = JOB_ERR;
        for (int j = NUM_JOBS - 1; j >= 0; j--)
        begin
            if (pending_reg[j])
            begin
                cur_job = job_t'(j[2:0]);
            end
        end
    end

    // jobs raised by a newly taken sample and the counter update
    always_comb
    begin
        count_fill = (count_reg < COUNT_FULL) ? count_reg + COUNT_W'(1) : COUNT_FULL;
        new_jobs   = '0;
        count_next = count_reg;
        if (accept)
        begin
            if (count_fill < COUNT_FULL)
            begin
                if (last)
                begin
                    new_jobs[JOB_ERR] = 1'b1;
                    count_next        = '0;
                end
                else
                begin
                    count_next = count_fill;
                end
            end
            else
            begin
                if (count_reg == COUNT_LAST_FILL)
                begin
                    new_jobs[JOB_FWD0] = 1'b1;
                    new_jobs[JOB_FWD1] = 1'b1;
                end
                new_jobs[JOB_CEN] = 1'b1;
                if (last)
                begin
                    new_jobs[JOB_BWD1] = 1'b1;
                    new_jobs[JOB_BWD0] = 1'b1;
                    count_next         = '0;
                end
                else
                begin
                    count_next = COUNT_FULL;
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            pending_next = new_jobs;
        end
        else if (issue)
        begin
            pending_next = remaining;
        end
        else
        begin
            pending_next = pending_reg;
        end
    end

    // stencil sums, oldest sample in f0
    assign f0 = SUM_W'($signed(taps[0]));
    assign f1 = SUM_W'($signed(taps[1]));
    assign f2 = SUM_W'($signed(taps[2]));
    assign f3 = SUM_W'($signed(taps[3]));
    assign f4 = SUM_W'($signed(taps[4]));

    always_comb
    begin
        case (cur_job)
            JOB_FWD0: stencil_sum = K35 * f0 - K104 * f1 + K114 * f2 - K56 * f3 + K11 * f4;
            JOB_FWD1: stencil_sum = K11 * f0 - K20 * f1 + K6 * f2 + K4 * f3 - f4;
            JOB_CEN:  stencil_sum = K16 * f1 - f0 - K30 * f2 + K16 * f3 - f4;
            JOB_BWD1: stencil_sum = K4 * f1 - f0 + K6 * f2 - K20 * f3 + K11 * f4;
            JOB_BWD0: stencil_sum = K11 * f0 - K56 * f1 + K114 * f2 - K104 * f3 + K35 * f4;
            default:  stencil_sum = '0;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_en ? (pending_reg != '0) : s1_valid_reg;
        s1_sum_next   = s1_sum_reg;
        s1_tag_next   = s1_tag_reg;
        if (issue)
        begin
            s1_sum_next           = stencil_sum;
            s1_tag_next.final_res = (cur_job == JOB_BWD0) || (cur_job == JOB_ERR);
            s1_tag_next.too_short = (cur_job == JOB_ERR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pending_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            pending_reg  <= pending_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sum_reg <= s1_sum_next;
        s1_tag_reg <= s1_tag_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_sum   = s1_sum_reg;
    assign s1_tag   = s1_tag_reg;

endmodule

// ===== design/fpsd_post.sv =====
module fpsd_post
    import fpsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int OUT_WIDTH    = OUT_WIDTH_DEF,
    localparam int SUM_W  = SAMPLE_WIDTH + COEF_GROWTH,
    localparam int PROD_W = SUM_W + SCALE_W + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [SCALE_W-1:0]          scale,
    input  logic [SHIFT_W-1:0]          shift,
    input  logic                        s1_valid,
    input  logic signed [SUM_W-1:0]     s1_sum,
    input  res_tag_t                    s1_tag,
    output logic                        post_ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_WIDTH-1:0] derivative,
    output logic                        final_res,
    output logic                        too_short
);

    logic                         prod_valid_reg;
    logic                         prod_valid_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     prod_next;
    res_tag_t                     prod_tag_reg;
    res_tag_t                     prod_tag_next;
    logic                         shr_valid_reg;
    logic                         shr_valid_next;
    logic signed [PROD_W-1:0]     shr_reg;
    logic signed [PROD_W-1:0]     shr_next;
    res_tag_t                     shr_tag_reg;
    res_tag_t                     shr_tag_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [OUT_WIDTH-1:0]  out_data_reg;
    logic signed [OUT_WIDTH-1:0]  out_data_next;
    res_tag_t                     out_tag_reg;
    res_tag_t                     out_tag_next;

    logic                         out_en;
    logic                         shr_en;
    logic                         prod_en;
    logic signed [SCALE_W:0]      scale_s;
    logic signed [OUT_WIDTH-1:0]  sat_value;

    // each stage moves when the one after it is empty or moving
    assign out_en     = !out_valid_reg || !out_stall;
    assign shr_en     = !shr_valid_reg || out_en;
    assign prod_en    = !prod_valid_reg || shr_en;
    assign post_ready = prod_en;

    // exact signed product, then floor via arithmetic shift
    assign scale_s = {1'b0, scale};

    always_comb
    begin
        prod_valid_next = prod_en ? s1_valid : prod_valid_reg;
        prod_next       = prod_en ? PROD_W'(s1_sum) * PROD_W'(scale_s) : prod_reg;
        prod_tag_next   = prod_en ? s1_tag : prod_tag_reg;

        shr_valid_next  = shr_en ? prod_valid_reg : shr_valid_reg;
        shr_next        = shr_en ? (prod_reg >>> shift) : shr_reg;
        shr_tag_next    = shr_en ? prod_tag_reg : shr_tag_reg;

        out_valid_next  = out_en ? shr_valid_reg : out_valid_reg;
        out_data_next   = out_en ? sat_value : out_data_reg;
        out_tag_next    = out_en ? shr_tag_reg : out_tag_reg;
    end

    // clamp to the output range
    generate
        if (PROD_W > OUT_WIDTH)
        begin : g_sat
            logic [PROD_W-OUT_WIDTH:0] top_bits;
            assign top_bits = shr_reg[PROD_W-1:OUT_WIDTH-1];
            always_comb
            begin
                if ((&top_bits) || !(|top_bits))
                begin
                    sat_value = shr_reg[OUT_WIDTH-1:0];
                end
                else if (shr_reg[PROD_W-1])
                begin
                    sat_value = {1'b1, {(OUT_WIDTH-1){1'b0}}};
                end
                else
                begin
                    sat_value = {1'b0, {(OUT_WIDTH-1){1'b1}}};
                end
            end
        end
        else
        begin : g_ext
            assign sat_value = OUT_WIDTH'(shr_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            shr_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            shr_valid_reg  <= shr_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_tag_reg <= prod_tag_next;
        shr_reg      <= shr_next;
        shr_tag_reg  <= shr_tag_next;
        out_data_reg <= out_data_next;
        out_tag_reg  <= out_tag_next;
    end

    assign out_valid  = out_valid_reg;
    assign derivative = out_data_reg;
    assign final_res  = out_tag_reg.final_res;
    assign too_short  = out_tag_reg.too_short;

endmodule

// ===== design/five_point_second_derivative_unit.sv =====
// a sample's first result passes the pending job, stencil sum, product, shift
//   and output registers; one sample per cycle in steady state if out_stall is low;
//   the fifth and the last sample of a sequence hold the input while their extra
//   jobs issue, as the single stencil adder emits one result per cycle
// reset: asynchronous, active low; clears the window, count and pipeline,
//   scale returns to 1 and shift to 0
module five_point_second_derivative_unit
    import fpsd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int OUT_WIDTH    = OUT_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    // sample input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                        last,

    // result output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_WIDTH-1:0] derivative,
    output logic                        final_res,
    output logic                        too_short,

    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int SUM_W = SAMPLE_WIDTH + COEF_GROWTH;

    logic [SCALE_W-1:0]      scale_reg;
    logic [SCALE_W-1:0]      scale_next;
    logic [SHIFT_W-1:0]      shift_reg;
    logic [SHIFT_W-1:0]      shift_next;

    logic                    shift_en;
    logic [SAMPLE_WIDTH-1:0] taps [WIN_DEPTH];
    logic [SAMPLE_WIDTH-1:0] chain_in [WIN_DEPTH];
    logic                    s1_valid;
    logic signed [SUM_W-1:0] s1_sum;
    res_tag_t                s1_tag;
    logic                    post_ready;

    // config registers are always ready; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        scale_next = scale_reg;
        shift_next = shift_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE: scale_next = cfg_data[SCALE_W-1:0];
                REG_SHIFT: shift_next = cfg_data[SHIFT_W-1:0];
                default:
                begin
                    scale_next = scale_reg;
                    shift_next = shift_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            shift_reg <= SHIFT_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
            shift_reg <= shift_next;
        end
    end

    // sample window: a row of cells, newest sample enters the top cell and
    // each cell hands its sample down on every input transfer, so cell 0
    // always holds the oldest of the last five samples
    generate
        for (genvar i = 0; i < WIN_DEPTH; i++)
        begin : g_cell
            if (i == WIN_DEPTH - 1)
            begin : g_head
                assign chain_in[i] = sample;
            end
            else
            begin : g_link
                assign chain_in[i] = taps[i+1];
            end

            fpsd_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (chain_in[i]),
                .q        (taps[i])
            );
        end
    endgenerate

    // counts samples, queues the stencil jobs each sample releases and
    // forms one integer stencil sum per cycle while the post stages accept it
    fpsd_seq #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last       (last),
        .shift_en   (shift_en),
        .taps       (taps),
        .post_ready (post_ready),
        .s1_valid   (s1_valid),
        .s1_sum     (s1_sum),
        .s1_tag     (s1_tag)
    );

    // scale multiply, floor shift, saturation and the output register
    fpsd_post #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .OUT_WIDTH    (OUT_WIDTH)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .scale      (scale_reg),
        .shift      (shift_reg),
        .s1_valid   (s1_valid),
        .s1_sum     (s1_sum),
        .s1_tag     (s1_tag),
        .post_ready (post_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .derivative (derivative),
        .final_res  (final_res),
        .too_short  (too_short)
    );

endmodule
